/* src/keyword_identifier_tokenizer_assert.svh */
// assertion macros used by the tokenizer checker
`ifndef KEYWORD_IDENTIFIER_TOKENIZER_ASSERT_SVH
`define KEYWORD_IDENTIFIER_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KIT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define KIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kit_pkg.sv */
package kit_pkg;

    // default depth of the command queue between front and back
    localparam int KIT_QUEUE_DEPTH = 4;

    typedef logic [3:0] kit_kind_t;

    // token kinds as they appear on token_kind
    localparam kit_kind_t KIND_KEYWORD = 4'd0;
    localparam kit_kind_t KIND_IDENT   = 4'd1;
    localparam kit_kind_t KIND_LIT     = 4'd2;
    localparam kit_kind_t KIND_LPAREN  = 4'd3;
    localparam kit_kind_t KIND_RPAREN  = 4'd4;
    localparam kit_kind_t KIND_LBRACK  = 4'd5;
    localparam kit_kind_t KIND_RBRACK  = 4'd6;
    localparam kit_kind_t KIND_LBRACE  = 4'd7;
    localparam kit_kind_t KIND_RBRACE  = 4'd8;
    localparam kit_kind_t KIND_SEMI    = 4'd9;
    localparam kit_kind_t KIND_ERROR   = 4'd10;
    localparam kit_kind_t KIND_END     = 4'd11;

    // keyword candidates
    localparam logic KW_RETURN = 1'b0;
    localparam logic KW_INT    = 1'b1;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // scanner state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_LIT,
        MODE_KEYWORD
    } kit_mode_t;

    // one queued command: a burst of keyword letters, then an optional tail beat
    typedef struct packed {
        logic [2:0] pre_n;
        logic       pre_cand;
        logic       pre_keyword;
        logic       tail_en;
        kit_kind_t  tail_kind;
        logic [7:0] tail_char;
        logic       tail_start;
    } kit_cmd_t;

    // letter idx of the keyword cand
    function automatic logic [7:0] kw_char(input logic cand, input logic [2:0] idx);
        logic [7:0] ch;
        case ({cand, idx})
            {KW_RETURN, 3'd0}: ch = 8'h72;
            {KW_RETURN, 3'd1}: ch = 8'h65;
            {KW_RETURN, 3'd2}: ch = 8'h74;
            {KW_RETURN, 3'd3}: ch = 8'h75;
            {KW_RETURN, 3'd4}: ch = 8'h72;
            {KW_RETURN, 3'd5}: ch = 8'h6E;
            {KW_INT, 3'd0}:    ch = 8'h69;
            {KW_INT, 3'd1}:    ch = 8'h6E;
            {KW_INT, 3'd2}:    ch = 8'h74;
            default:           ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_len(input logic cand);
        return (cand == KW_INT) ? 3'd3 : 3'd6;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] b);
        return ((b >= CH_UPPER_A) && (b <= CH_LOWER_Z)) || (b == CH_UNDER);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_ident_start(b) || is_digit(b);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_NL) || (b == CH_SPACE);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACK) ||
               (b == CH_RBRACK) || (b == CH_LBRACE) || (b == CH_RBRACE) ||
               (b == CH_SEMI);
    endfunction

    function automatic kit_kind_t punct_kind(input logic [7:0] b);
        kit_kind_t k;
        case (b)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

/* src/keyword_identifier_tokenizer.sv */
// channel  | direction | handshake                | payload
// text     | in        | text_valid / text_stall  | text_byte, end_of_text
// token    | out       | token_valid / token_stall| token_kind, token_char, token_start,
//          |           |                          | last_of_run
//
// one text beat per cycle enters while the command queue has room; the front
// classifies it in the same cycle and queues at most one command
// the back turns each command into one token beat per cycle while not stalled, so a
// completed keyword or a flushed run of held letters makes up to six token beats
// a text beat's tokens leave through the queue and then the output register
// rst_n clears scanner state, queue pointers and the output valid at once
// token_stall holds the output register; text_stall rises only when the queue is full
module keyword_identifier_tokenizer #(
    parameter int QUEUE_DEPTH = kit_pkg::KIT_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output logic               token_valid,
    input  logic               token_stall,
    output kit_pkg::kit_kind_t token_kind,
    output logic [7:0]         token_char,
    output logic               token_start,
    output logic               last_of_run
);
    import kit_pkg::*;

    kit_cmd_t front_cmd;
    kit_cmd_t head_cmd;
    logic     front_push;
    logic     q_full;
    logic     q_empty;
    logic     back_pop;
    logic     text_accept;

    assign text_stall  = q_full;
    assign text_accept = text_valid && !q_full;

    // classify and track scanner state
    kit_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (text_accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .push        (front_push),
        .cmd         (front_cmd)
    );

    // decoupling queue
    kit_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (back_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // expand commands into token beats
    kit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .head_valid  (!q_empty),
        .pop         (back_pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .token_char  (token_char),
        .token_start (token_start),
        .last_of_run (last_of_run)
    );

endmodule

/* src/kit_front.sv */
module kit_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output logic              push,
    output kit_pkg::kit_cmd_t cmd
);
    import kit_pkg::*;

    kit_mode_t  mode_reg, mode_next;
    logic       cand_reg, cand_next;
    logic [2:0] cnt_reg, cnt_next;

    // token-start classification of the current byte
    kit_mode_t  ts_mode;
    logic       ts_kw;
    logic       ts_tail_en;
    kit_kind_t  ts_kind;

    always_comb
    begin
        ts_mode    = MODE_IDLE;
        ts_kw      = 1'b0;
        ts_tail_en = 1'b0;
        ts_kind    = KIND_ERROR;
        if (is_space(text_byte))
        begin
            ts_mode = MODE_IDLE;
        end
        else if (is_punct(text_byte))
        begin
            ts_tail_en = 1'b1;
            ts_kind    = punct_kind(text_byte);
        end
        else if ((text_byte == CH_LOWER_R) || (text_byte == CH_LOWER_I))
        begin
            ts_mode = MODE_KEYWORD;
            ts_kw   = 1'b1;
        end
        else if (is_ident_start(text_byte))
        begin
            ts_mode    = MODE_IDENT;
            ts_tail_en = 1'b1;
            ts_kind    = KIND_IDENT;
        end
        else if (is_digit(text_byte))
        begin
            ts_mode    = MODE_LIT;
            ts_tail_en = 1'b1;
            ts_kind    = KIND_LIT;
        end
        else
        begin
            ts_tail_en = 1'b1;
            ts_kind    = KIND_ERROR;
        end
    end

    // keyword prefix compare
    logic [2:0] kw_n;
    logic       kw_hit;
    logic       kw_done;
    logic [2:0] held_n;

    assign kw_n    = kw_len(cand_reg);
    assign kw_hit  = (cnt_reg != 3'd0) && (cnt_reg < kw_n) &&
                     (text_byte == kw_char(cand_reg, cnt_reg));
    assign kw_done = kw_hit && ((cnt_reg + 3'd1) == kw_n);
    assign held_n  = (cnt_reg > kw_n) ? kw_n : cnt_reg;

    // next scanner state
    always_comb
    begin
        mode_next = mode_reg;
        cand_next = cand_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                mode_next = MODE_IDLE;
                cand_next = KW_RETURN;
                cnt_next  = 3'd0;
            end
            else
            begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (!is_ident_char(text_byte))
                        begin
                            mode_next = ts_mode;
                        end
                    end
                    MODE_LIT:
                    begin
                        if (!is_digit(text_byte))
                        begin
                            mode_next = ts_mode;
                            // a keyword letter right after a literal opens a candidate
                            if (ts_kw)
                            begin
                                cand_next = (text_byte == CH_LOWER_I) ? KW_INT : KW_RETURN;
                                cnt_next  = 3'd1;
                            end
                        end
                    end
                    MODE_KEYWORD:
                    begin
                        if (kw_hit)
                        begin
                            if (kw_done)
                            begin
                                mode_next = MODE_IDLE;
                                cnt_next  = 3'd0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            cnt_next  = 3'd0;
                            mode_next = is_ident_char(text_byte) ? MODE_IDENT : ts_mode;
                        end
                    end
                    default:
                    begin
                        mode_next = ts_mode;
                        if (ts_kw)
                        begin
                            cand_next = (text_byte == CH_LOWER_I) ? KW_INT : KW_RETURN;
                            cnt_next  = 3'd1;
                        end
                    end
                endcase
            end
        end
    end

    // command for the back end
    always_comb
    begin
        cmd            = '0;
        cmd.pre_cand   = cand_reg;
        cmd.tail_char  = text_byte;
        cmd.tail_start = 1'b1;
        cmd.tail_kind  = ts_kind;
        if (end_of_text)
        begin
            cmd.pre_n     = (mode_reg == MODE_KEYWORD) ? held_n : 3'd0;
            cmd.tail_en   = 1'b1;
            cmd.tail_kind = KIND_END;
            cmd.tail_char = CH_NUL;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_ident_char(text_byte))
                    begin
                        cmd.tail_en    = 1'b1;
                        cmd.tail_kind  = KIND_IDENT;
                        cmd.tail_start = 1'b0;
                    end
                    else
                    begin
                        cmd.tail_en = ts_tail_en;
                    end
                end
                MODE_LIT:
                begin
                    if (is_digit(text_byte))
                    begin
                        cmd.tail_en    = 1'b1;
                        cmd.tail_kind  = KIND_LIT;
                        cmd.tail_start = 1'b0;
                    end
                    else
                    begin
                        cmd.tail_en = ts_tail_en;
                    end
                end
                MODE_KEYWORD:
                begin
                    if (kw_hit)
                    begin
                        if (kw_done)
                        begin
                            cmd.pre_n       = kw_n;
                            cmd.pre_keyword = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.pre_n = held_n;
                        if (is_ident_char(text_byte))
                        begin
                            cmd.tail_en    = 1'b1;
                            cmd.tail_kind  = KIND_IDENT;
                            cmd.tail_start = (held_n == 3'd0);
                        end
                        else
                        begin
                            cmd.tail_en = ts_tail_en;
                        end
                    end
                end
                default:
                begin
                    cmd.tail_en = ts_tail_en;
                end
            endcase
        end
    end

    assign push = accept && ((cmd.pre_n != 3'd0) || cmd.tail_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cand_reg <= KW_RETURN;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            cand_reg <= cand_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* src/kit_queue.sv */
module kit_queue #(
    parameter int DEPTH = kit_pkg::KIT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kit_pkg::kit_cmd_t push_cmd,
    input  logic              pop,
    output kit_pkg::kit_cmd_t head_cmd,
    output logic              full,
    output logic              empty
);
    import kit_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kit_cmd_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/kit_back.sv */
module kit_back (
    input  logic              clk,
    input  logic              rst_n,
    input  kit_pkg::kit_cmd_t head_cmd,
    input  logic              head_valid,
    output logic              pop,
    output logic              token_valid,
    input  logic              token_stall,
    output kit_pkg::kit_kind_t token_kind,
    output logic [7:0]        token_char,
    output logic              token_start,
    output logic              last_of_run
);
    import kit_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    kit_kind_t  kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic       start_reg, start_next;
    logic       last_reg, last_next;

    logic [2:0] total;
    logic       is_last;
    logic       load;

    assign total   = head_cmd.pre_n + {2'b00, head_cmd.tail_en};
    assign is_last = (idx_reg == (total - 3'd1));
    assign load    = head_valid && (!valid_reg || !token_stall);
    assign pop     = load && is_last;

    // pick the beat at idx: held letters first, then the tail
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && token_stall;
        kind_next  = kind_reg;
        char_next  = char_reg;
        start_next = start_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = is_last;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            if (idx_reg < head_cmd.pre_n)
            begin
                kind_next  = head_cmd.pre_keyword ? KIND_KEYWORD : KIND_IDENT;
                char_next  = kw_char(head_cmd.pre_cand, idx_reg);
                start_next = (idx_reg == 3'd0);
            end
            else
            begin
                kind_next  = head_cmd.tail_kind;
                char_next  = head_cmd.tail_char;
                start_next = head_cmd.tail_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        char_reg  <= char_next;
        start_reg <= start_next;
        last_reg  <= last_next;
    end

    assign token_valid = valid_reg;
    assign token_kind  = kind_reg;
    assign token_char  = char_reg;
    assign token_start = start_reg;
    assign last_of_run = last_reg;

endmodule

/* src/kit_checker.sv */
`include "keyword_identifier_tokenizer_assert.svh"

module kit_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               text_valid,
    input logic               text_stall,
    input logic [7:0]         text_byte,
    input logic               end_of_text,
    input logic               token_valid,
    input logic               token_stall,
    input kit_pkg::kit_kind_t token_kind,
    input logic [7:0]         token_char,
    input logic               token_start,
    input logic               last_of_run
);
    import kit_pkg::*;

    // a stalled token beat holds
    `KIT_ASSERT_NEXT(a_token_hold, token_valid && token_stall, token_valid && $stable(token_kind) && $stable(token_char) && $stable(token_start) && $stable(last_of_run), "stalled token beat changed")

    // kinds stay in range
    `KIT_ASSERT_IMPL(a_kind_range, token_valid, token_kind <= KIND_END, "token kind out of range")

    // end marker is a lone start beat with a zero char
    `KIT_ASSERT_IMPL(a_end_form, token_valid && (token_kind == KIND_END), (token_char == CH_NUL) && token_start && last_of_run, "bad end marker")

    // single-character tokens start and close their run
    `KIT_ASSERT_IMPL(a_single_char, token_valid && (token_kind >= KIND_LPAREN) && (token_kind <= KIND_ERROR), token_start && last_of_run, "single-char token not standalone")

endmodule

bind keyword_identifier_tokenizer kit_checker u_kit_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import kit_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_DIRECTED = 27;

    localparam logic [47:0] RETURN_WORD = "return";
    localparam logic [23:0] INT_WORD = "int";
    localparam logic [7:0] PUNCT_CHARS [7] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                                               CH_LBRACE, CH_RBRACE, CH_SEMI};
    localparam logic [7:0] BLANK_CHARS [3] = '{CH_TAB, CH_NL, CH_SPACE};

    // one token beat as it leaves the block
    typedef struct {
        kit_kind_t  kind;
        logic [7:0] ch;
        logic       start;
        logic       last;
    } token_beat_t;

    // directed row; kind and char are only used when the result is typed in
    typedef struct {
        logic [7:0] text;
        logic       eot;
        logic       typed;
        kit_kind_t  kind;
        logic [7:0] ch;
    } text_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               text_valid = 1'b0;
    logic               text_stall;
    logic [7:0]         text_byte = 8'h00;
    logic               end_of_text = 1'b0;
    logic               token_valid;
    logic               token_stall = 1'b0;
    kit_kind_t          token_kind;
    logic [7:0]         token_char;
    logic               token_start;
    logic               last_of_run;

    // scanner copy kept by the predictor
    kit_mode_t          scan_state;
    logic               kw_cand;
    logic [2:0]         kw_held;

    token_beat_t        run_beats[$];
    token_beat_t        token_expect_q[$];

    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 cycle_count = 0;
    int                 failures = 0;
    int                 text_beats = 0;
    int                 counted_items = 0;
    int                 end_markers = 0;
    int                 tokens_seen = 0;
    int                 keywords_seen = 0;
    int                 errors_seen = 0;

    text_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00,     1'b1, 1'b1, KIND_END,    CH_NUL},
        '{8'h00,     1'b0, 1'b1, KIND_ERROR,  8'h00},
        '{8'hFF,     1'b0, 1'b1, KIND_ERROR,  8'hFF},
        '{CH_LPAREN, 1'b0, 1'b1, KIND_LPAREN, CH_LPAREN},
        '{CH_RPAREN, 1'b0, 1'b1, KIND_RPAREN, CH_RPAREN},
        '{CH_LBRACK, 1'b0, 1'b1, KIND_LBRACK, CH_LBRACK},
        '{CH_RBRACK, 1'b0, 1'b1, KIND_RBRACK, CH_RBRACK},
        '{CH_LBRACE, 1'b0, 1'b1, KIND_LBRACE, CH_LBRACE},
        '{CH_RBRACE, 1'b0, 1'b1, KIND_RBRACE, CH_RBRACE},
        '{CH_SEMI,   1'b0, 1'b1, KIND_SEMI,   CH_SEMI},
        '{"r",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"e",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"t",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"u",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"r",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"n",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_LOWER_Z, 1'b0, 1'b0, KIND_ERROR, 8'h00},
        '{CH_LBRACK, 1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_SPACE,  1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"i",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"n",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_ZERO,   1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_TAB,    1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_ZERO,   1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{CH_NINE,   1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{"r",       1'b0, 1'b0, KIND_ERROR,  8'h00},
        '{8'hA5,     1'b1, 1'b0, KIND_ERROR,  8'h00}
    };

    keyword_identifier_tokenizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .token_char  (token_char),
        .token_start (token_start),
        .last_of_run (last_of_run)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // letter idx of the keyword candidate
    function automatic logic [7:0] keyword_letter(input logic cand, input int idx);
        logic [47:0] word;
        word = (cand == KW_INT) ? {INT_WORD, 24'h0} : RETURN_WORD;
        return word[8 * (5 - idx) +: 8];
    endfunction

    // append one expected beat to the current run
    function automatic void add_beat(input kit_kind_t kind, input logic [7:0] ch,
                                     input logic start);
        token_beat_t beat;
        beat.kind  = kind;
        beat.ch    = ch;
        beat.start = start;
        beat.last  = 1'b0;
        run_beats.insert(run_beats.size(), beat);
    endfunction

    // held keyword letters come out as identifier characters
    function automatic void flush_held_letters();
        for (int i = 0; i < int'(kw_held); i++)
            add_beat(KIND_IDENT, keyword_letter(kw_cand, i), i == 0);
        kw_held = 3'd0;
    endfunction

    // byte seen between tokens
    function automatic void begin_token(input logic [7:0] b);
        scan_state = MODE_IDLE;
        case (b)
            CH_TAB, CH_NL, CH_SPACE: ;
            CH_LPAREN: add_beat(KIND_LPAREN, b, 1'b1);
            CH_RPAREN: add_beat(KIND_RPAREN, b, 1'b1);
            CH_LBRACK: add_beat(KIND_LBRACK, b, 1'b1);
            CH_RBRACK: add_beat(KIND_RBRACK, b, 1'b1);
            CH_LBRACE: add_beat(KIND_LBRACE, b, 1'b1);
            CH_RBRACE: add_beat(KIND_RBRACE, b, 1'b1);
            CH_SEMI:   add_beat(KIND_SEMI, b, 1'b1);
            CH_LOWER_R, CH_LOWER_I:
            begin
                scan_state = MODE_KEYWORD;
                kw_cand = (b == CH_LOWER_I) ? KW_INT : KW_RETURN;
                kw_held = 3'd1;
            end
            default:
            begin
                if ((b >= CH_UPPER_A && b <= CH_LOWER_Z) || b == CH_UNDER)
                begin
                    add_beat(KIND_IDENT, b, 1'b1);
                    scan_state = MODE_IDENT;
                end
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    add_beat(KIND_LIT, b, 1'b1);
                    scan_state = MODE_LIT;
                end
                else
                    add_beat(KIND_ERROR, b, 1'b1);
            end
        endcase
    endfunction

    // tokens caused by one text beat, left in run_beats
    function automatic void predict_tokens(input logic [7:0] b, input logic eot);
        logic       numeral;
        logic       word_body;
        logic [2:0] klen;
        numeral = (b >= CH_ZERO) && (b <= CH_NINE);
        word_body = numeral || (b >= CH_UPPER_A && b <= CH_LOWER_Z) || b == CH_UNDER;
        klen = (kw_cand == KW_INT) ? 3'd3 : 3'd6;
        run_beats = {};
        if (eot)
        begin
            if (scan_state == MODE_KEYWORD)
                flush_held_letters();
            add_beat(KIND_END, CH_NUL, 1'b1);
            scan_state = MODE_IDLE;
            kw_cand = KW_RETURN;
            kw_held = 3'd0;
        end
        else
        begin
            case (scan_state)
                MODE_IDENT:
                    if (word_body)
                        add_beat(KIND_IDENT, b, 1'b0);
                    else
                        begin_token(b);
                MODE_LIT:
                    if (numeral)
                        add_beat(KIND_LIT, b, 1'b0);
                    else
                        begin_token(b);
                MODE_KEYWORD:
                    if (kw_held >= 3'd1 && kw_held < klen &&
                        b == keyword_letter(kw_cand, int'(kw_held)))
                    begin
                        kw_held = kw_held + 3'd1;
                        if (kw_held == klen)
                        begin
                            for (int i = 0; i < int'(klen); i++)
                                add_beat(KIND_KEYWORD, keyword_letter(kw_cand, i), i == 0);
                            kw_held = 3'd0;
                            scan_state = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        flush_held_letters();
                        if (word_body)
                        begin
                            add_beat(KIND_IDENT, b, run_beats.size() == 0);
                            scan_state = MODE_IDENT;
                        end
                        else
                            begin_token(b);
                    end
                default:
                    begin_token(b);
            endcase
        end
        if (run_beats.size() > 0)
            run_beats[run_beats.size() - 1].last = 1'b1;
    endfunction

    // present one text beat, wait for it to be taken, queue its tokens
    task automatic send_text(input logic [7:0] b, input logic eot, input logic typed,
                             input kit_kind_t kind, input logic [7:0] ch);
        while ($urandom_range(99) < gap_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (text_stall);
        text_beats++;
        counted_items++;
        if (eot)
            end_markers++;
        predict_tokens(b, eot);
        if (typed)
        begin
            run_beats = {};
            add_beat(kind, ch, 1'b1);
            run_beats[0].last = 1'b1;
        end
        foreach (run_beats[i])
            token_expect_q.insert(token_expect_q.size(), run_beats[i]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_text(b, 1'b0, 1'b0, KIND_ERROR, CH_NUL);
    endtask

    // sender holds off until every queued token has come out
    task automatic drain_tokens();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (token_expect_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_word_char(input bit with_digits);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return CH_UNDER;
        if (with_digits && sel < 3)
            return CH_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(CH_LOWER_Z, CH_UPPER_A));
    endfunction

    // one random piece of program text, mostly well-formed
    task automatic send_random_piece();
        int   pick;
        int   n;
        int   cut;
        logic cand;
        pick = $urandom_range(99);
        cand = 1'($urandom_range(1));
        n = (cand == KW_INT) ? 3 : 6;
        if (pick < 25)
        begin
            // whole keyword, maybe glued to the next word
            for (int i = 0; i < n; i++)
                send_byte(keyword_letter(cand, i));
            if ($urandom_range(1))
                send_byte(pick_word_char(1'b1));
        end
        else if (pick < 40)
        begin
            // keyword cut short by some other byte, or by end of text
            cut = $urandom_range(n - 1, 1);
            for (int i = 0; i < cut; i++)
                send_byte(keyword_letter(cand, i));
            case ($urandom_range(3))
                0:       send_byte(8'($urandom_range(255)));
                1:       send_text(8'($urandom_range(255)), 1'b1, 1'b0, KIND_ERROR, CH_NUL);
                2:       send_byte(PUNCT_CHARS[$urandom_range(6)]);
                default: send_byte(pick_word_char(1'b1));
            endcase
        end
        else if (pick < 55)
        begin
            send_byte(pick_word_char(1'b0));
            repeat ($urandom_range(5))
                send_byte(pick_word_char(1'b1));
        end
        else if (pick < 65)
        begin
            repeat ($urandom_range(5, 1))
                send_byte(CH_ZERO + 8'($urandom_range(9)));
        end
        else if (pick < 77)
            send_byte(PUNCT_CHARS[$urandom_range(6)]);
        else if (pick < 94)
            send_byte(8'($urandom_range(255)));
        else
            send_text(8'($urandom_range(255)), 1'b1, 1'b0, KIND_ERROR, CH_NUL);
        if ($urandom_range(1))
            send_byte(BLANK_CHARS[$urandom_range(2)]);
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        token_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // token checker
    always @(posedge clk)
    begin
        token_beat_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            tokens_seen++;
            if (token_kind == KIND_KEYWORD && token_start)
                keywords_seen++;
            if (token_kind == KIND_ERROR)
                errors_seen++;
            if (token_expect_q.size() == 0)
            begin
                $display("%0t: unexpected token beat kind %0d char %02h start %0b last %0b",
                         $time, token_kind, token_char, token_start, last_of_run);
                failures++;
            end
            else
            begin
                want = token_expect_q.pop_front();
                if (token_kind !== want.kind || token_char !== want.ch ||
                    token_start !== want.start || last_of_run !== want.last)
                begin
                    $display("%0t: token mismatch, expected kind %0d char %02h start %0b last %0b",
                             $time, want.kind, want.ch, want.start, want.last);
                    $display("%0t:                 actual kind %0d char %02h start %0b last %0b",
                             $time, token_kind, token_char, token_start, last_of_run);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d token beats still expected",
                     cycle_count, token_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        scan_state = MODE_IDLE;
        kw_cand = KW_RETURN;
        kw_held = 3'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i])
            send_text(directed_rows[i].text, directed_rows[i].eot, directed_rows[i].typed,
                      directed_rows[i].kind, directed_rows[i].ch);
        drain_tokens();

        // random text under three idle and stall mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 28 : (phase == 1) ? 52 : 0;
            stall_pct = (phase == 0) ? 52 : (phase == 1) ? 28 : 0;
            counted_items = 0;
            while (counted_items < ITEMS_PER_PHASE)
                send_random_piece();
            drain_tokens();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d text beats with %0d end markers, checked %0d token beats",
                 text_beats, end_markers, tokens_seen);
        $display("saw %0d keywords and %0d error tokens across three idle/stall mixes",
                 keywords_seen, errors_seen);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
